// ===== hw/rtl/psfrm_pkg.sv =====
// Shared types and constants of the per-source flow rate meter.
// Table entry layout, FSM states, config register indexes, result record.
// No dependencies.
package psfrm_pkg;

    // Table geometry: bucket = low address bits, slot = bucket * WAYS + way.
    localparam int BUCKETS = 8192;
    localparam int WAYS    = 4;
    localparam int BKT_W   = $clog2(BUCKETS);

    // Iterative divider geometry: 32-bit dividend, divisor is the 12-bit interval.
    localparam int DIV_N = 32;
    localparam int DIV_D = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_EXT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_WRN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INC_WRN  = 3'd5;

    localparam logic [11:0] INTERVAL_RST = 12'd60;
    localparam logic [11:0] IDLE_EXT_RST = 12'd30;
    localparam logic [13:0] TICKS_RST    = 14'd100;
    localparam logic [15:0] LIMIT_RST    = 16'd32768;
    localparam logic [21:0] RATE_WRN_RST = 22'd2048;
    localparam logic [15:0] INC_WRN_RST  = 16'd512;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    // Exempt sources: loopback /8, the all-zero address and the 10.251/16 management net.
    localparam logic [7:0]  LOOPBACK_NET = 8'd127;
    localparam logic [15:0] MGMT_NET     = {8'd10, 8'd251};

    // 1024 and 1024*1024 as shifts
    localparam int KIB_SH = 10;
    localparam int MIB_SH = 20;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] last;
        logic [31:0] ibytes;
        logic [39:0] inc;
        logic [31:0] pkts;
        logic [47:0] bytes;
        logic [31:0] ralm;
        logic [31:0] ialm;
    } t_entry;

    typedef struct packed {
        logic        verdict;
        logic        table_full;
        logic        slot_valid;
        logic        evicted;
        logic [31:0] entry_address;
        logic [31:0] rate;
        logic        rate_alarm;
        logic        increase_alarm;
        logic [31:0] rate_alarm_count;
        logic [31:0] increase_alarm_count;
        logic [31:0] total_packets;
        logic [47:0] total_bytes;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_RDIV
    } t_state;

    function automatic logic is_exempt(input logic [31:0] a);
        is_exempt = (a[31:24] == LOOPBACK_NET) || (a == 32'd0) || (a[31:16] == MGMT_NET);
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== hw/rtl/per_source_flow_rate_meter.sv =====
// Per-source flow rate meter. Exempt packets and out-of-range slots are answered
// in the idle state; packets, empty and evicted sweeps pass through the read and
// evaluate states; rated sweeps then wait in ST_RDIV for the 32-step rate divider.
// One item at a time; busy is low again while o_done is high. o_done strobes each
// result for one cycle, the receiver cannot stall. After reset the table is cleared
// one bucket per cycle with busy high; config writes are taken meanwhile.
module per_source_flow_rate_meter import psfrm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [31:0]           i_source_address,
    input  logic [15:0]           i_packet_length,
    input  logic [31:0]           i_now_ticks,
    input  logic [14:0]           i_slot_index,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // results
    output logic                  o_done,
    output logic                  o_verdict,
    output logic                  o_table_full,
    output logic                  o_slot_valid,
    output logic                  o_evicted,
    output logic [31:0]           o_entry_address,
    output logic [31:0]           o_rate_bytes_per_second,
    output logic                  o_rate_alarm,
    output logic                  o_increase_alarm,
    output logic [31:0]           o_rate_alarm_count,
    output logic [31:0]           o_increase_alarm_count,
    output logic [31:0]           o_total_packets,
    output logic [47:0]           o_total_bytes
);

    localparam int   SLOTS     = BUCKETS * WAYS;
    localparam int   WAY_SH    = $clog2(WAYS);
    localparam int   WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

    // ---------------- configuration ----------------
    logic [11:0] r_interval, r_idle_ext;
    logic [13:0] r_ticks;
    logic [15:0] r_limit;
    logic [21:0] r_rate_wrn;
    logic [15:0] r_inc_wrn;
    logic [26:0] r_idle_lim;   // (interval + extra) * ticks, refreshed every cycle

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_idle_ext <= IDLE_EXT_RST;
            r_ticks    <= TICKS_RST;
            r_limit    <= LIMIT_RST;
            r_rate_wrn <= RATE_WRN_RST;
            r_inc_wrn  <= INC_WRN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INTERVAL: r_interval <= i_cfg_data[11:0];
                REG_IDLE_EXT: r_idle_ext <= i_cfg_data[11:0];
                REG_TICKS:    r_ticks    <= i_cfg_data[13:0];
                REG_LIMIT:    r_limit    <= i_cfg_data[15:0];
                REG_RATE_WRN: r_rate_wrn <= i_cfg_data[21:0];
                REG_INC_WRN:  r_inc_wrn  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
        r_idle_lim <= (27'(r_interval) + 27'(r_idle_ext)) * 27'(r_ticks);
    end

    // ---------------- control and item registers ----------------
    t_state          r_state, n_state;
    logic [BKT_W-1:0] r_clr, n_clr;
    logic            r_op, n_op;
    logic [31:0]     r_addr, n_addr;
    logic [15:0]     r_len, n_len;
    logic [31:0]     r_now, n_now;
    logic [BKT_W-1:0] r_bkt, n_bkt;
    logic [WAY_W-1:0] r_way, n_way;
    logic [15:0]     r_occ, n_occ;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    // table port
    logic              mem_we, mem_re;
    logic [BKT_W-1:0]  mem_waddr;
    t_entry [WAYS-1:0] mem_wdata, rd_row;

    // divider port
    logic              div_start, div_done;
    logic [DIV_N-1:0]  div_dividend, div_quo;
    logic [DIV_D-1:0]  div_divisor;

    psfrm_table u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_bkt),
        .o_rdata (rd_row)
    );

    psfrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // ---------------- shared decode ----------------
    logic accept, in_exempt, in_oor;
    assign accept    = start && !busy;
    assign in_exempt = is_exempt(i_source_address);
    assign in_oor    = (32'(i_slot_index) >= 32'(SLOTS));

    // way search over the read row (lowest way wins)
    logic [WAY_W-1:0] hit_w, free_w;
    logic             have_hit, have_free;
    always_comb begin
        hit_w     = '0;
        free_w    = '0;
        have_hit  = 1'b0;
        have_free = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_row[w].valid && (rd_row[w].key == r_addr)) begin
                hit_w    = WAY_W'(w);
                have_hit = 1'b1;
            end
            if (!rd_row[w].valid) begin
                free_w    = WAY_W'(w);
                have_free = 1'b1;
            end
        end
    end

    t_entry sel_ent, hit_ent;
    assign sel_ent = rd_row[r_way];
    assign hit_ent = rd_row[hit_w];

    // idle check for the swept slot
    logic [31:0] idle_diff;
    logic        sw_evict;
    assign idle_diff = r_now - sel_ent.last;
    assign sw_evict  = (idle_diff > 32'(r_idle_lim));

    // packet update of a known entry, saturating
    t_entry    pk_upd, pk_new;
    logic [48:0] bsum;
    logic [32:0] isum;
    logic [40:0] csum;
    always_comb begin
        bsum          = {1'b0, hit_ent.bytes} + 49'(r_len);
        isum          = {1'b0, hit_ent.ibytes} + 33'(r_len);
        csum          = {1'b0, hit_ent.inc} + 41'(r_len);
        pk_upd        = hit_ent;
        pk_upd.pkts   = sat_inc32(hit_ent.pkts);
        pk_upd.bytes  = bsum[48] ? '1 : bsum[47:0];
        pk_upd.ibytes = isum[32] ? '1 : isum[31:0];
        pk_upd.inc    = csum[40] ? '1 : csum[39:0];
        pk_upd.last   = r_now;

        pk_new        = '0;
        pk_new.valid  = 1'b1;
        pk_new.key    = r_addr;
        pk_new.last   = r_now;
        pk_new.ibytes = 32'(r_len);
        pk_new.inc    = 40'(r_len);
        pk_new.pkts   = 32'd1;
        pk_new.bytes  = 48'(r_len);
    end

    // sweep finish: rate alarm, increase alarm, accumulator clear
    logic   sw_ralarm, sw_ialarm;
    t_entry sw_upd;
    always_comb begin
        sw_ralarm     = (div_quo >= {r_rate_wrn, KIB_SH'(0)});
        sw_ialarm     = (sel_ent.inc >= {4'd0, r_inc_wrn, MIB_SH'(0)});
        sw_upd        = sel_ent;
        sw_upd.ibytes = '0;
        if (sw_ralarm) begin
            sw_upd.ralm = sat_inc32(sel_ent.ralm);
        end
        if (sw_ialarm) begin
            sw_upd.ialm = sat_inc32(sel_ent.ialm);
            sw_upd.inc  = '0;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_PACKET) begin
                        if (!in_exempt) n_state = ST_READ;
                    end else begin
                        if (!in_oor)    n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_op == OP_PACKET || !sel_ent.valid || sw_evict) n_state = ST_IDLE;
                else                                                  n_state = ST_RDIV;
            end
            ST_RDIV: begin
                if (div_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath / outputs ----------------
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_addr       = r_addr;
        n_len        = r_len;
        n_now        = r_now;
        n_bkt        = r_bkt;
        n_way        = r_way;
        n_occ        = r_occ;
        n_done       = 1'b0;
        n_res        = r_res;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_bkt;
        mem_wdata    = rd_row;
        div_start    = 1'b0;
        // rate divide: zero interval divides as one
        div_dividend = sel_ent.ibytes;
        div_divisor  = (r_interval == 12'd0) ? DIV_D'(1) : DIV_D'(r_interval);

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op   = i_operation;
                    n_addr = i_source_address;
                    n_len  = i_packet_length;
                    n_now  = i_now_ticks;
                    if (i_operation == OP_PACKET) begin
                        if (in_exempt) begin
                            n_res  = '0;
                            n_done = 1'b1;
                        end else begin
                            n_bkt = i_source_address[BKT_W-1:0];
                        end
                    end else begin
                        if (in_oor) begin
                            n_res  = '0;
                            n_done = 1'b1;
                        end else begin
                            n_bkt = BKT_W'(i_slot_index >> WAY_SH);
                            n_way = WAY_W'(i_slot_index & 15'(WAYS - 1));
                        end
                    end
                end
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_EVAL: begin
                if (r_op == OP_PACKET) begin
                    n_res         = '0;
                    n_res.verdict = 1'b1;
                    n_done        = 1'b1;
                    if (have_hit) begin
                        mem_we           = 1'b1;
                        mem_wdata[hit_w] = pk_upd;
                    end else if (r_occ >= r_limit) begin
                        n_res.table_full = 1'b1;
                    end else if (have_free) begin
                        mem_we            = 1'b1;
                        mem_wdata[free_w] = pk_new;
                        if (r_occ != 16'hFFFF) n_occ = r_occ + 16'd1;
                    end else begin
                        n_res.table_full = 1'b1;
                    end
                end else begin
                    n_res = '0;
                    if (!sel_ent.valid) begin
                        n_done = 1'b1;
                    end else if (sw_evict) begin
                        n_done                     = 1'b1;
                        mem_we                     = 1'b1;
                        mem_wdata[r_way].valid     = 1'b0;
                        if (r_occ != 16'd0) n_occ  = r_occ - 16'd1;
                        n_res.slot_valid           = 1'b1;
                        n_res.evicted              = 1'b1;
                        n_res.entry_address        = sel_ent.key;
                        n_res.rate_alarm_count     = sel_ent.ralm;
                        n_res.increase_alarm_count = sel_ent.ialm;
                        n_res.total_packets        = sel_ent.pkts;
                        n_res.total_bytes          = sel_ent.bytes;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_RDIV: begin
                if (div_done) begin
                    mem_we                     = 1'b1;
                    mem_wdata[r_way]           = sw_upd;
                    n_done                     = 1'b1;
                    n_res                      = '0;
                    n_res.slot_valid           = 1'b1;
                    n_res.entry_address        = sel_ent.key;
                    n_res.rate                 = div_quo;
                    n_res.rate_alarm           = sw_ralarm;
                    n_res.increase_alarm       = sw_ialarm;
                    n_res.rate_alarm_count     = sw_upd.ralm;
                    n_res.increase_alarm_count = sw_upd.ialm;
                    n_res.total_packets        = sw_upd.pkts;
                    n_res.total_bytes          = sw_upd.bytes;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_occ   <= n_occ;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_addr <= n_addr;
        r_len  <= n_len;
        r_now  <= n_now;
        r_bkt  <= n_bkt;
        r_way  <= n_way;
        r_res  <= n_res;
    end

    // ---------------- ports ----------------
    assign busy                    = (r_state != ST_IDLE);
    assign o_done                  = r_done;
    assign o_verdict               = r_res.verdict;
    assign o_table_full            = r_res.table_full;
    assign o_slot_valid            = r_res.slot_valid;
    assign o_evicted               = r_res.evicted;
    assign o_entry_address         = r_res.entry_address;
    assign o_rate_bytes_per_second = r_res.rate;
    assign o_rate_alarm            = r_res.rate_alarm;
    assign o_increase_alarm        = r_res.increase_alarm;
    assign o_rate_alarm_count      = r_res.rate_alarm_count;
    assign o_increase_alarm_count  = r_res.increase_alarm_count;
    assign o_total_packets         = r_res.total_packets;
    assign o_total_bytes           = r_res.total_bytes;

endmodule

// ===== hw/rtl/psfrm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used for the sweep rate. Uses psfrm_pkg.
module psfrm_div import psfrm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_N-1:0] i_dividend,
    input  logic [DIV_D-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_N-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_N);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_N-1:0] r_quo, n_quo;
    logic [DIV_D-1:0] r_rem, n_rem;
    logic [DIV_D-1:0] r_dvs, n_dvs;
    logic [DIV_D:0]   shifted, trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[DIV_N-1]};
        trial   = shifted - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!trial[DIV_D]) begin
                n_rem = trial[DIV_D-1:0];
                n_quo = {r_quo[DIV_N-2:0], 1'b1};
            end else begin
                n_rem = shifted[DIV_D-1:0];
                n_quo = {r_quo[DIV_N-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_N - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/psfrm_table.sv =====
// Flow table: one row per bucket holding all ways, one write and one
// registered read port. Uses psfrm_pkg for the entry layout and geometry.
module psfrm_table import psfrm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [BKT_W-1:0]      i_waddr,
    input  t_entry [WAYS-1:0]     i_wdata,
    input  logic                  i_re,
    input  logic [BKT_W-1:0]      i_raddr,
    output t_entry [WAYS-1:0]     o_rdata
);

    t_entry [WAYS-1:0] mem [BUCKETS];
    t_entry [WAYS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/per_source_flow_rate_meter_test.sv =====
// Self-checking testbench of the per-source flow rate meter.
// Depends on psfrm_pkg and per_source_flow_rate_meter; it holds its own table model.
module per_source_flow_rate_meter_test;
    import psfrm_pkg::*;

    localparam int NSLOT = BUCKETS * WAYS;
    localparam int DRAIN_CYCLES = 80;    // longest sweep with divides, plus margin
    localparam int STALL_LIMIT = 40000;  // covers the table clear after reset

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_operation;
    logic [31:0]           i_source_address;
    logic [15:0]           i_packet_length;
    logic [31:0]           i_now_ticks;
    logic [14:0]           i_slot_index;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic                  o_verdict;
    logic                  o_table_full;
    logic                  o_slot_valid;
    logic                  o_evicted;
    logic [31:0]           o_entry_address;
    logic [31:0]           o_rate_bytes_per_second;
    logic                  o_rate_alarm;
    logic                  o_increase_alarm;
    logic [31:0]           o_rate_alarm_count;
    logic [31:0]           o_increase_alarm_count;
    logic [31:0]           o_total_packets;
    logic [47:0]           o_total_bytes;

    per_source_flow_rate_meter dut (.*);

    // Meter model: table contents and register copies.
    bit          tbl_valid [NSLOT];
    bit [31:0]   tbl_key   [NSLOT];
    bit [31:0]   tbl_last  [NSLOT];
    bit [31:0]   tbl_ibytes[NSLOT];
    bit [39:0]   tbl_inc   [NSLOT];
    bit [31:0]   tbl_pkts  [NSLOT];
    bit [47:0]   tbl_bytes [NSLOT];
    bit [31:0]   tbl_ralm  [NSLOT];
    bit [31:0]   tbl_ialm  [NSLOT];
    bit [15:0]   occupied;
    bit [11:0]   cfg_interval;
    bit [11:0]   cfg_idle_ext;
    bit [13:0]   cfg_ticks;
    bit [15:0]   cfg_limit;
    bit [21:0]   cfg_rate_wrn;
    bit [15:0]   cfg_inc_wrn;

    t_result     pending_results[$];
    int          error_count;
    int          stall_cycles;
    bit          idle_on;       // sender gaps enabled
    bit [31:0]   clock_now;     // stimulus time base
    bit [31:0]   hi_pool[8];    // upper address bits shared by colliding sources

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- model ----------------
    function automatic bit source_exempt(bit [31:0] a);
        return a[31:24] == 8'd127 || a == 32'd0 || a[31:16] == {8'd10, 8'd251};
    endfunction

    function automatic t_result meter_packet(bit [31:0] addr, bit [15:0] len, bit [31:0] now);
        t_result r;
        int base;
        int s;
        r = '0;
        if (source_exempt(addr)) return r;
        r.verdict = 1'b1;
        base = int'(addr[12:0]) * WAYS;
        for (int w = 0; w < WAYS; w++) begin
            s = base + w;
            if (tbl_valid[s] && tbl_key[s] == addr) begin
                if (tbl_pkts[s] != '1) tbl_pkts[s]++;
                tbl_bytes[s]  = (49'(tbl_bytes[s]) + len > 49'hFFFF_FFFF_FFFF)
                                ? '1 : tbl_bytes[s] + len;
                tbl_ibytes[s] = (33'(tbl_ibytes[s]) + len > 33'hFFFF_FFFF)
                                ? '1 : tbl_ibytes[s] + len;
                tbl_inc[s]    = (41'(tbl_inc[s]) + len > 41'hFF_FFFF_FFFF)
                                ? '1 : tbl_inc[s] + len;
                tbl_last[s]   = now;
                return r;
            end
        end
        if (32'(occupied) >= 32'(cfg_limit)) begin
            r.table_full = 1'b1;
            return r;
        end
        for (int w = 0; w < WAYS; w++) begin
            s = base + w;
            if (!tbl_valid[s]) begin
                tbl_valid[s]  = 1'b1;
                tbl_key[s]    = addr;
                tbl_last[s]   = now;
                tbl_ibytes[s] = 32'(len);
                tbl_inc[s]    = 40'(len);
                tbl_pkts[s]   = 1;
                tbl_bytes[s]  = 48'(len);
                tbl_ralm[s]   = 0;
                tbl_ialm[s]   = 0;
                if (occupied != 16'hFFFF) occupied++;
                return r;
            end
        end
        r.table_full = 1'b1;    // every way of the bucket taken
        return r;
    endfunction

    function automatic t_result meter_sweep(bit [14:0] idx, bit [31:0] now);
        t_result r;
        bit [31:0] idle_ticks;
        bit [63:0] idle_max;
        bit [31:0] divisor;
        bit [63:0] rate;
        r = '0;
        if (!tbl_valid[idx]) return r;
        r.slot_valid    = 1'b1;
        r.entry_address = tbl_key[idx];
        idle_ticks = now - tbl_last[idx];
        idle_max = (64'(cfg_interval) + cfg_idle_ext) * cfg_ticks;
        if (64'(idle_ticks) > idle_max) begin
            tbl_valid[idx] = 1'b0;
            if (occupied != 0) occupied--;
            r.evicted = 1'b1;
        end else begin
            divisor = (cfg_interval == 0) ? 32'd1 : 32'(cfg_interval);
            rate = 64'(tbl_ibytes[idx] / divisor);
            r.rate = rate[31:0];
            if (rate >= 64'(cfg_rate_wrn) * 1024) begin
                r.rate_alarm = 1'b1;
                if (tbl_ralm[idx] != '1) tbl_ralm[idx]++;
            end
            tbl_ibytes[idx] = '0;
            if (64'(tbl_inc[idx]) >= 64'(cfg_inc_wrn) * 1024 * 1024) begin
                r.increase_alarm = 1'b1;
                if (tbl_ialm[idx] != '1) tbl_ialm[idx]++;
                tbl_inc[idx] = '0;
            end
        end
        r.rate_alarm_count     = tbl_ralm[idx];
        r.increase_alarm_count = tbl_ialm[idx];
        r.total_packets        = tbl_pkts[idx];
        r.total_bytes          = tbl_bytes[idx];
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %0s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Results cannot be held off: every strobe is one transfer.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'd1, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_verdict !== want.verdict)
                    report_mismatch("verdict", 64'(o_verdict), 64'(want.verdict));
                if (o_table_full !== want.table_full)
                    report_mismatch("table_full", 64'(o_table_full), 64'(want.table_full));
                if (o_slot_valid !== want.slot_valid)
                    report_mismatch("slot_valid", 64'(o_slot_valid), 64'(want.slot_valid));
                if (o_evicted !== want.evicted)
                    report_mismatch("evicted", 64'(o_evicted), 64'(want.evicted));
                if (o_entry_address !== want.entry_address)
                    report_mismatch("entry_address", 64'(o_entry_address),
                                    64'(want.entry_address));
                if (o_rate_bytes_per_second !== want.rate)
                    report_mismatch("rate", 64'(o_rate_bytes_per_second), 64'(want.rate));
                if (o_rate_alarm !== want.rate_alarm)
                    report_mismatch("rate_alarm", 64'(o_rate_alarm), 64'(want.rate_alarm));
                if (o_increase_alarm !== want.increase_alarm)
                    report_mismatch("increase_alarm", 64'(o_increase_alarm),
                                    64'(want.increase_alarm));
                if (o_rate_alarm_count !== want.rate_alarm_count)
                    report_mismatch("rate_alarm_count", 64'(o_rate_alarm_count),
                                    64'(want.rate_alarm_count));
                if (o_increase_alarm_count !== want.increase_alarm_count)
                    report_mismatch("increase_alarm_count", 64'(o_increase_alarm_count),
                                    64'(want.increase_alarm_count));
                if (o_total_packets !== want.total_packets)
                    report_mismatch("total_packets", 64'(o_total_packets),
                                    64'(want.total_packets));
                if (o_total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", 64'(o_total_bytes),
                                    64'(want.total_bytes));
            end
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // One command transfer. start stays high into the next call unless a gap is taken.
    task automatic send_item(bit op, bit [31:0] addr, bit [15:0] len, bit [31:0] now,
                             bit [14:0] slot);
        while (idle_on && $urandom_range(99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_operation      <= op;
        i_source_address <= addr;
        i_packet_length  <= len;
        i_now_ticks      <= now;
        i_slot_index     <= slot;
        do @(posedge i_clk); while (busy);
        if (op == OP_PACKET) pending_results.push_back(meter_packet(addr, len, now));
        else pending_results.push_back(meter_sweep(slot, now));
    endtask

    task automatic send_packet(bit [31:0] addr, bit [15:0] len);
        send_item(OP_PACKET, addr, len, clock_now, 15'($urandom));
    endtask

    task automatic send_sweep(bit [14:0] slot);
        send_item(OP_SWEEP, 32'($urandom), 16'($urandom), clock_now, slot);
    endtask

    // Let all results arrive, then a quiet margin so the block is idle.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_INTERVAL: cfg_interval = val[11:0];
            REG_IDLE_EXT: cfg_idle_ext = val[11:0];
            REG_TICKS:    cfg_ticks    = val[13:0];
            REG_LIMIT:    cfg_limit    = val[15:0];
            REG_RATE_WRN: cfg_rate_wrn = val[21:0];
            REG_INC_WRN:  cfg_inc_wrn  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int ivl, int idl, int tps, int lim, int rw, int iw);
        drain();
        write_reg(REG_INTERVAL, CFG_DATA_W'(ivl));
        write_reg(REG_IDLE_EXT, CFG_DATA_W'(idl));
        write_reg(REG_TICKS, CFG_DATA_W'(tps));
        write_reg(REG_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_RATE_WRN, CFG_DATA_W'(rw));
        write_reg(REG_INC_WRN, CFG_DATA_W'(iw));
    endtask

    // Sources that collide in the first few buckets, so buckets fill up.
    function automatic bit [31:0] pooled_source();
        return {hi_pool[$urandom_range(7)][31:13], 13'($urandom_range(7))};
    endfunction

    // ---------------- tests ----------------
    task automatic test_exempt_sources;
        send_packet(32'h7F00_0001, 16'hFFFF);
        send_packet(32'h7FFF_FFFF, 16'd0);
        send_packet(32'h0000_0000, 16'd100);
        send_packet(32'h0AFB_1234, 16'd64);
        send_packet(32'h0AFA_0001, 16'd64);     // just outside the management net
    endtask

    // Fill one bucket past its ways, then sweep it: empty slot, rate, eviction.
    task automatic test_bucket_and_sweep;
        for (int k = 0; k < WAYS + 1; k++)
            send_packet({19'(k + 1), 13'h1FFF}, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, 16'd0);      // FFFF_FFFF sits in bucket 1FFF too
        send_packet({19'd1, 13'h1FFF}, 16'd1);
        send_sweep(15'h7FFC);
        send_sweep(15'd0);                      // never written
        clock_now += 32'd9000;                  // exactly at the idle limit
        send_sweep(15'h7FFD);
        clock_now += 32'd1;
        send_sweep(15'h7FFD);                   // one tick past: evicted
        send_sweep(15'h7FFD);
        send_sweep(15'h7FFF);
    endtask

    // Register extremes: zero interval, zero thresholds, zero and full limit.
    task automatic test_register_extremes;
        write_all(0, 0, 1, 0, 0, 0);
        send_packet(32'h0102_0003, 16'd10);     // limit zero: refused
        write_all(0, 3600, 10000, 32768, 0, 0);
        send_packet(32'h0102_0003, 16'hFFFF);
        send_sweep(15'd12);                     // both alarms, divide by one
        send_sweep(15'd12);
        write_all(3600, 0, 1, 1, 22'h3FFFFF, 16'hFFFF);
        send_packet(32'h0102_0004, 16'd5);      // lowered limit blocks insertion
        clock_now = 32'hFFFF_F000;              // wrap the time base
        send_sweep(15'd12);
        write_all(60, 30, 100, 32768, 2048, 512);
    endtask

    task automatic test_random_traffic;
        bit [14:0] slot;
        int        phase_len;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_all(1, 0, 1, 32768, 0, 0);
                1: write_all($urandom_range(1, 4), $urandom_range(0, 3),
                             $urandom_range(1, 100), $urandom_range(3, 20),
                             $urandom_range(0, 1), $urandom_range(0, 1));
                2: write_all(60, 30, 100, 32768, 2048, 512);
                3: write_all(3600, 3600, 10000, 32768, 22'h3FFFFF, 16'hFFFF);
                default: write_all(2, 1, 50, 6, 0, 1);
            endcase
            idle_on   = (phase != 2);           // phase 2 runs back to back
            phase_len = 400;
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(99) < 3) clock_now += $urandom_range(5000, 400000);
                else clock_now += $urandom_range(0, 300);
                if ($urandom_range(2) == 0) begin
                    slot = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(31));
                    send_sweep(slot);
                end else if ($urandom_range(9) == 0) begin
                    send_packet($urandom, 16'($urandom));
                end else begin
                    send_packet(pooled_source(), 16'($urandom));
                end
            end
        end
    endtask

    initial begin
        start            <= 1'b0;
        i_operation      <= OP_PACKET;
        i_source_address <= '0;
        i_packet_length  <= '0;
        i_now_ticks      <= '0;
        i_slot_index     <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        error_count  = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        clock_now    = 32'h0000_1000;
        occupied     = 0;
        cfg_interval = 60;
        cfg_idle_ext = 30;
        cfg_ticks    = 100;
        cfg_limit    = 16'd32768;
        cfg_rate_wrn = 2048;
        cfg_inc_wrn  = 512;
        foreach (hi_pool[k]) hi_pool[k] = $urandom | 32'h2000_0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_exempt_sources();
        test_bucket_and_sweep();
        test_register_extremes();
        test_random_traffic();
        drain();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
